// File: rtl/core/mcc_pkg.sv
// ----------------------------------------------------------------------------
// mcc_pkg: shared types and constants of the column consensus core
// Holds the symbol classifier, the slot to letter map and the control bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mcc_pkg;

	localparam int NUM_SLOTS  = 21;
	localparam int SLOT_W     = 5;
	localparam int COUNT_W    = 11;
	localparam int TOTAL_W    = 16;
	localparam int PCT_W      = 7;
	localparam int PROD_TOP_W = 18;
	localparam int PROD_TOT_W = 23;

	localparam logic [SLOT_W-1:0]  GAP_SLOT   = 5'd20;
	localparam logic [SLOT_W-1:0]  AMINO_LAST = 5'd19;
	localparam logic [SLOT_W-1:0]  NUC_LAST   = 5'd3;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 11'd2047;
	localparam logic [PCT_W-1:0]   PCT_RESET  = 7'd50;
	localparam logic [PROD_TOP_W-1:0] PCT_FULL = 18'd100;

	localparam logic [7:0] CHAR_GAP  = 8'h2D;
	localparam logic [7:0] CHAR_N    = 8'h4E;
	localparam logic [7:0] CHAR_X    = 8'h58;
	localparam logic [7:0] CASE_BIT  = 8'h20;
	localparam logic [7:0] LOWER_A   = 8'h61;
	localparam logic [7:0] LOWER_Z   = 8'h7A;
	localparam logic [7:0] UPPER_A   = 8'h41;
	localparam logic [7:0] UPPER_Z   = 8'h5A;

	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic {
		CFG_ALPHABET_MODE = 1'b0,
		CFG_MIN_AGREE_PCT = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		AGR_UNANIMOUS = 2'd0,
		AGR_MAJORITY  = 2'd1,
		AGR_WILDCARD  = 2'd2
	} agree_t;

	typedef struct packed {
		logic  vote;
		slot_t slot;
	} cls_t;

	typedef struct packed {
		logic count;
		logic scan_start;
		logic scan_step;
		logic mult;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_blocked;
	} status_t;

	function automatic cls_t classify(input logic [7:0] sym, input logic nuc);
		logic [7:0] up;
		cls_t r;
		r.vote = 1'b1;
		r.slot = GAP_SLOT;
		up = (sym >= LOWER_A && sym <= LOWER_Z) ? (sym & ~CASE_BIT) : sym;
		if (sym != CHAR_GAP) begin
			if (nuc) begin
				case (up)
					"A": r.slot = 5'd0;
					"C": r.slot = 5'd1;
					"G": r.slot = 5'd2;
					"T", "U": r.slot = 5'd3;
					default: r.vote = 1'b0;
				endcase
			end else begin
				case (up)
					"A": r.slot = 5'd0;
					"C": r.slot = 5'd1;
					"D": r.slot = 5'd2;
					"E": r.slot = 5'd3;
					"F": r.slot = 5'd4;
					"G": r.slot = 5'd5;
					"H": r.slot = 5'd6;
					"I": r.slot = 5'd7;
					"K": r.slot = 5'd8;
					"L": r.slot = 5'd9;
					"M": r.slot = 5'd10;
					"N": r.slot = 5'd11;
					"P": r.slot = 5'd12;
					"Q": r.slot = 5'd13;
					"R": r.slot = 5'd14;
					"S": r.slot = 5'd15;
					"T": r.slot = 5'd16;
					"V": r.slot = 5'd17;
					"W": r.slot = 5'd18;
					"Y": r.slot = 5'd19;
					default: r.vote = 1'b0;
				endcase
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] slot_letter(input slot_t slot, input logic nuc);
		logic [7:0] c;
		c = CHAR_X;
		if (nuc) begin
			case (slot[1:0])
				2'd0: c = "A";
				2'd1: c = "C";
				2'd2: c = "G";
				2'd3: c = "T";
				default: c = CHAR_N;
			endcase
		end else begin
			case (slot)
				5'd0: c = "A";
				5'd1: c = "C";
				5'd2: c = "D";
				5'd3: c = "E";
				5'd4: c = "F";
				5'd5: c = "G";
				5'd6: c = "H";
				5'd7: c = "I";
				5'd8: c = "K";
				5'd9: c = "L";
				5'd10: c = "M";
				5'd11: c = "N";
				5'd12: c = "P";
				5'd13: c = "Q";
				5'd14: c = "R";
				5'd15: c = "S";
				5'd16: c = "T";
				5'd17: c = "V";
				5'd18: c = "W";
				5'd19: c = "Y";
				default: c = CHAR_X;
			endcase
		end
		return c;
	endfunction

endpackage

// File: rtl/core/mcc_ctrl.sv
// ----------------------------------------------------------------------------
// mcc_ctrl: sequencer of the column consensus core
// Accepts symbols, then walks the datapath through the column-end scan, the
// threshold products and the result load.
// ----------------------------------------------------------------------------
module mcc_ctrl import mcc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    column_end,
	output logic    in_stall,
	output cmd_t    cmd,
	input  status_t status
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MULT,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   in_stall_q;
	logic   accept;

	assign in_stall = in_stall_q;
	assign accept   = in_valid && !in_stall_q && (state_q == ST_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.count      = accept;
		cmd.scan_start = accept && column_end;
		cmd.scan_step  = (state_q == ST_SCAN);
		cmd.mult       = (state_q == ST_MULT);
		cmd.finish     = (state_q == ST_FINISH) && !status.out_blocked;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && column_end) begin
						state_q    <= ST_SCAN;
						in_stall_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (status.scan_last)
						state_q <= ST_MULT;
				end
				ST_MULT: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					// Hold until the output register is free to take the result.
					if (!status.out_blocked) begin
						state_q    <= ST_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_stall_q <= 1'b0;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_end_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && column_end) |=> in_stall)
		else $error("column end transfer did not stall the input");
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !status.out_blocked)
		else $error("result load while the output register is held");
	a_stall_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input open while a column is being resolved");
`endif

endmodule

// File: rtl/core/mcc_datapath.sv
// ----------------------------------------------------------------------------
// mcc_datapath: vote counters, scan unit and output register
// Holds the configuration, the 21 saturating vote counters, the serial
// top-count scan, the threshold products and the result register.
// ----------------------------------------------------------------------------
module mcc_datapath import mcc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [PCT_W-1:0]  cfg_data,
	input  logic [7:0]        symbol,
	input  cmd_t              cmd,
	output status_t           status,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        cons_char,
	output logic [1:0]        agreement
);

	logic                  mode_q;
	logic [PCT_W-1:0]      pct_q;
	count_t                counts_q [NUM_SLOTS];
	slot_t                 idx_q;
	slot_t                 top_idx_q;
	count_t                top_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [PROD_TOP_W-1:0] prod_top_q;
	logic [PROD_TOT_W-1:0] prod_tot_q;
	logic                  out_valid_q;
	logic [7:0]            cons_char_q;
	agree_t                agreement_q;

	cls_t       cls;
	count_t     scan_val;
	slot_t      idx_next;
	logic       emit;
	logic [7:0] letter;

	assign cls      = classify(symbol, mode_q);
	assign scan_val = counts_q[idx_q];
	assign idx_next = (idx_q == (mode_q ? NUC_LAST : AMINO_LAST)) ? GAP_SLOT
	                  : idx_q + 5'd1;
	assign emit     = (total_q != '0) && (top_idx_q != GAP_SLOT);
	assign letter   = slot_letter(top_idx_q, mode_q);

	assign status.scan_last   = (idx_q == GAP_SLOT);
	assign status.out_blocked = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign cons_char = cons_char_q;
	assign agreement = agreement_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			pct_q  <= PCT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ALPHABET_MODE: mode_q <= cfg_data[0];
				CFG_MIN_AGREE_PCT: pct_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++)
				counts_q[i] <= '0;
		end else if (cmd.finish) begin
			for (int i = 0; i < NUM_SLOTS; i++)
				counts_q[i] <= '0;
		end else if (cmd.count && cls.vote && counts_q[cls.slot] != COUNT_MAX) begin
			counts_q[cls.slot] <= counts_q[cls.slot] + 11'd1;
		end
	end

	// Serial scan: letters in alphabet order, then the gap slot; a strict
	// compare keeps the earliest slot on a tie.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			top_idx_q <= GAP_SLOT;
			top_q     <= '0;
			total_q   <= '0;
		end else if (cmd.scan_start) begin
			idx_q     <= '0;
			top_idx_q <= GAP_SLOT;
			top_q     <= '0;
			total_q   <= '0;
		end else if (cmd.scan_step) begin
			idx_q   <= idx_next;
			total_q <= total_q + TOTAL_W'(scan_val);
			if (scan_val > top_q) begin
				top_q     <= scan_val;
				top_idx_q <= idx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mult) begin
			prod_top_q <= PROD_TOP_W'(top_q) * PCT_FULL;
			prod_tot_q <= PROD_TOT_W'(pct_q) * PROD_TOT_W'(total_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (TOTAL_W'(top_q) == total_q) begin
				cons_char_q <= letter;
				agreement_q <= AGR_UNANIMOUS;
			end else if (PROD_TOT_W'(prod_top_q) >= prod_tot_q) begin
				cons_char_q <= letter | CASE_BIT;
				agreement_q <= AGR_MAJORITY;
			end else begin
				cons_char_q <= mode_q ? CHAR_N : CHAR_X;
				agreement_q <= AGR_WILDCARD;
			end
		end
	end

`ifndef SYNTHESIS
	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (counts_q[0] == '0 && counts_q[NUM_SLOTS-1] == '0))
		else $error("vote counters not cleared after column end");
	a_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && agreement_q == AGR_UNANIMOUS) |->
		(cons_char_q >= UPPER_A && cons_char_q <= UPPER_Z))
		else $error("unanimous result is not an upper case letter");
	a_top_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mult |-> (TOTAL_W'(top_q) <= total_q))
		else $error("top count exceeds column total");
`endif

endmodule

// File: rtl/core/msa_column_consensus_core.sv
// ----------------------------------------------------------------------------
// msa_column_consensus_core: majority consensus of alignment columns
// Counts votes of one alignment column and emits the consensus character.
// ----------------------------------------------------------------------------
// Usage: symbols of a column arrive on the input channel (symbol, column_end)
// with in_valid/in_stall; column_end marks the last row of the column. After
// the column-end transfer the input stalls while the scan unit walks the
// counters one slot a cycle, 5 slots for nucleotides and 21 for amino acids,
// then forms the threshold products and loads the result register. The
// result (cons_char, agreement) is offered on out_valid/out_stall; columns
// that are empty or won by gaps give no transfer. The next column's symbols
// are accepted while a result still waits on a stalled receiver; a later
// column end holds in the final step until the waiting result has been taken.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Reset clears all vote counters and sets nucleotide mode off and the
// agreement threshold to 50 percent.
// ----------------------------------------------------------------------------
module msa_column_consensus_core import mcc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [PCT_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       symbol,
	input  logic             column_end,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       cons_char,
	output logic [1:0]       agreement
);

	cmd_t    cmd;
	status_t status;

	mcc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.column_end (column_end),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.status     (status)
	);

	mcc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.symbol    (symbol),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cons_char (cons_char),
		.agreement (agreement)
	);

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for msa_column_consensus_core
// Feeds alignment columns through the symbol channel and predicts each
// consensus character in step with every accepted transfer. A short table of
// directed columns comes first, then random columns under several register
// settings. Both sides idle in short random bursts. Once, the receiver holds
// off long enough for the core to stall its input.
// ----------------------------------------------------------------------------
module testbench import mcc_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT       = 1000000;
	localparam int DRAIN       = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 270;
	localparam int GAP_IDX     = 20;

	localparam logic [7:0] AMINO_ABC [20] = '{"A", "C", "D", "E", "F", "G", "H", "I", "K",
		"L", "M", "N", "P", "Q", "R", "S", "T", "V", "W", "Y"};
	localparam logic [7:0] NUC_ABC [4] = '{"A", "C", "G", "T"};

	typedef struct packed {
		logic [7:0] ch;
		agree_t     ag;
	} cons_t;

	typedef enum logic [1:0] {
		RK_VOTE,
		RK_EMPTY,
		RK_CHAR,
		RK_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		cfg_idx_t   sel;
		logic [7:0] data;
		logic       eoc;
		logic [7:0] ch;
		agree_t     ag;
	} plan_row_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [PCT_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_stall;
	logic [7:0]       symbol;
	logic             column_end;
	logic             out_valid;
	logic             out_stall;
	logic [7:0]       cons_char;
	logic [1:0]       agreement;

	// Predictor state, kept in step with the core.
	logic [COUNT_W-1:0] tally [21];
	logic               nuc_mode;
	logic [PCT_W-1:0]   agree_pct;

	cons_t     cons_due[$];
	plan_row_t plan[$];
	int        errors;
	int        cycles;
	bit        quiet;
	bit        hold_req;

	msa_column_consensus_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.symbol(symbol),
		.column_end(column_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cons_char(cons_char),
		.agreement(agreement)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int vote_slot(input logic [7:0] s, input logic nuc);
		logic [7:0] up;
		int slot;
		slot = -1;
		up = (s >= "a" && s <= "z") ? s - 8'd32 : s;
		if (s == "-") begin
			slot = GAP_IDX;
		end else if (nuc) begin
			if (up == "U")
				slot = 3;
			for (int i = 0; i < 4; i++)
				if (up == NUC_ABC[i])
					slot = i;
		end else begin
			for (int i = 0; i < 20; i++)
				if (up == AMINO_ABC[i])
					slot = i;
		end
		return slot;
	endfunction

	function automatic logic [7:0] pick_letter();
		return nuc_mode ? NUC_ABC[$urandom_range(0, 3)] : AMINO_ABC[$urandom_range(0, 19)];
	endfunction

	task automatic due_add(input cons_t res);
		cons_due.insert(cons_due.size(), res);
	endtask

	task automatic add_row(input plan_row_t row);
		plan.insert(plan.size(), row);
	endtask

	// Counts one symbol and, at a column end, works out the consensus.
	task automatic consensus_step(input logic [7:0] s, input logic eoc, output logic got,
		output cons_t res);
		int slot, size, top, top_i, total, v;
		logic [7:0] letter;
		got = 1'b0;
		res = '{8'h00, AGR_UNANIMOUS};
		slot = vote_slot(s, nuc_mode);
		if (slot >= 0 && tally[slot] != '1)
			tally[slot]++;
		if (eoc) begin
			size = nuc_mode ? 4 : 20;
			top = 0;
			top_i = GAP_IDX + 1;
			total = 0;
			for (int i = 0; i <= size; i++) begin
				v = int'(tally[i == size ? GAP_IDX : i]);
				total += v;
				if (v > top) begin
					top = v;
					top_i = i;
				end
			end
			if (total != 0 && top_i != size) begin
				got = 1'b1;
				letter = nuc_mode ? NUC_ABC[top_i] : AMINO_ABC[top_i];
				if (top == total)
					res = '{letter, AGR_UNANIMOUS};
				else if (100 * top >= int'(agree_pct) * total)
					res = '{letter + 8'd32, AGR_MAJORITY};
				else
					res = '{nuc_mode ? 8'h4E : 8'h58, AGR_WILDCARD};
			end
			foreach (tally[i])
				tally[i] = '0;
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("%0t: mismatch in %s: got %h, wanted %h", $realtime, what, got, want);
		errors++;
	endtask

	// Offers one symbol and waits for its transfer, then runs the predictor.
	task automatic offer_symbol(input logic [7:0] s, input logic eoc, input logic keep_pred);
		logic got;
		cons_t res;
		if (!quiet && $urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 3)) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		@(negedge clk);
		in_valid <= 1'b1;
		symbol <= s;
		column_end <= eoc;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		consensus_step(s, eoc, got, res);
		if (got && keep_pred)
			due_add(res);
	endtask

	// Columns that give no result leave no trace, so the core gets a full scan time.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (cons_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t sel, input logic [PCT_W-1:0] data);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (sel == CFG_ALPHABET_MODE)
			nuc_mode = data[0];
		else
			agree_pct = data;
	endtask

	task automatic feed_column(input logic [7:0] lead, input int len, inout int fed);
		logic [7:0] s;
		int r;
		for (int k = 0; k < len; k++) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				s = lead;
			else if (r < 80)
				s = pick_letter();
			else if (r < 88)
				s = "-";
			else
				s = 8'($urandom_range(0, 255));
			if (r < 80 && nuc_mode && s == "T" && $urandom_range(0, 2) == 0)
				s = "U";
			if (r < 80 && $urandom_range(0, 1) == 1)
				s = s | 8'h20;
			fed++;
			offer_symbol(s, k == len - 1, 1'b1);
		end
	endtask

	always @(posedge clk) begin
		cons_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (cons_due.size() == 0) begin
				flag_mismatch("unexpected result", cons_char, 8'h00);
			end else begin
				want = cons_due.pop_front();
				if (cons_char !== want.ch)
					flag_mismatch("cons_char", cons_char, want.ch);
				if (agreement !== want.ag)
					flag_mismatch("agreement", {6'd0, agreement}, {6'd0, want.ag});
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: short random stalls, one long hold-off on request.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int fed, len;
		logic [7:0] lead;
		int pct_plan [4];
		pct_plan = '{100, 0, 127, 50};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		symbol = 8'h00;
		column_end = 1'b0;
		errors = 0;
		cycles = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		nuc_mode = 1'b0;
		agree_pct = 7'd50;
		foreach (tally[i])
			tally[i] = '0;

		// Amino acids at the reset threshold of 50 percent.
		add_row('{RK_CHAR, CFG_ALPHABET_MODE, "M", 1'b1, "M", AGR_UNANIMOUS});
		add_row('{RK_VOTE, CFG_ALPHABET_MODE, "a", 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_CHAR, CFG_ALPHABET_MODE, "A", 1'b1, "A", AGR_UNANIMOUS});
		add_row('{RK_EMPTY, CFG_ALPHABET_MODE, "-", 1'b1, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_VOTE, CFG_ALPHABET_MODE, 8'hFF, 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_CHAR, CFG_ALPHABET_MODE, "y", 1'b1, "Y", AGR_UNANIMOUS});
		add_row('{RK_EMPTY, CFG_ALPHABET_MODE, 8'h00, 1'b1, 8'h00, AGR_UNANIMOUS});
		// A three-way tie goes to the earliest letter, which then lacks a majority.
		add_row('{RK_VOTE, CFG_ALPHABET_MODE, "C", 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_VOTE, CFG_ALPHABET_MODE, "D", 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_CHAR, CFG_ALPHABET_MODE, "-", 1'b1, "X", AGR_WILDCARD});
		add_row('{RK_VOTE, CFG_ALPHABET_MODE, "W", 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_VOTE, CFG_ALPHABET_MODE, "w", 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_CHAR, CFG_ALPHABET_MODE, "y", 1'b1, "w", AGR_MAJORITY});
		add_row('{RK_VOTE, CFG_ALPHABET_MODE, "-", 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_VOTE, CFG_ALPHABET_MODE, "-", 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_EMPTY, CFG_ALPHABET_MODE, "K", 1'b1, 8'h00, AGR_UNANIMOUS});
		// Nucleotides; the upper data bits of the mode write must be dropped.
		add_row('{RK_WRITE, CFG_ALPHABET_MODE, 8'h7F, 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_WRITE, CFG_MIN_AGREE_PCT, 8'h00, 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_VOTE, CFG_ALPHABET_MODE, "u", 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_VOTE, CFG_ALPHABET_MODE, "T", 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_CHAR, CFG_ALPHABET_MODE, "g", 1'b1, "t", AGR_MAJORITY});
		add_row('{RK_VOTE, CFG_ALPHABET_MODE, "E", 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_EMPTY, CFG_ALPHABET_MODE, "n", 1'b1, 8'h00, AGR_UNANIMOUS});
		// A threshold above 100 turns every split column into the wildcard.
		add_row('{RK_WRITE, CFG_MIN_AGREE_PCT, 8'h7F, 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_VOTE, CFG_ALPHABET_MODE, "A", 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_VOTE, CFG_ALPHABET_MODE, "a", 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_CHAR, CFG_ALPHABET_MODE, "c", 1'b1, "N", AGR_WILDCARD});
		// Mode switches in the middle of a column: votes keep the slot they got.
		add_row('{RK_WRITE, CFG_MIN_AGREE_PCT, 8'd50, 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_VOTE, CFG_ALPHABET_MODE, "T", 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_VOTE, CFG_ALPHABET_MODE, "t", 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_VOTE, CFG_ALPHABET_MODE, "u", 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_WRITE, CFG_ALPHABET_MODE, 8'h7E, 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_CHAR, CFG_ALPHABET_MODE, "c", 1'b1, "e", AGR_MAJORITY});
		add_row('{RK_VOTE, CFG_ALPHABET_MODE, "Y", 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_VOTE, CFG_ALPHABET_MODE, "y", 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_WRITE, CFG_ALPHABET_MODE, 8'h01, 1'b0, 8'h00, AGR_UNANIMOUS});
		add_row('{RK_CHAR, CFG_ALPHABET_MODE, "g", 1'b1, "G", AGR_UNANIMOUS});

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			case (plan[i].kind)
				RK_WRITE: write_reg(plan[i].sel, plan[i].data[PCT_W-1:0]);
				RK_VOTE: offer_symbol(plan[i].data, plan[i].eoc, 1'b1);
				RK_EMPTY: offer_symbol(plan[i].data, plan[i].eoc, 1'b0);
				default: begin
					offer_symbol(plan[i].data, plan[i].eoc, 1'b0);
					due_add('{plan[i].ch, plan[i].ag});
				end
			endcase
		end

		for (int p = 0; p < PHASES; p++) begin
			write_reg(CFG_ALPHABET_MODE, p < 4 ? {6'($urandom_range(0, 63)), 1'(p % 2)} :
				7'($urandom_range(0, 127)));
			write_reg(CFG_MIN_AGREE_PCT, p < 4 ? 7'(pct_plan[p]) : 7'($urandom_range(0, 127)));
			if (p == 1)
				hold_req = 1'b1;
			if (p == PHASES - 1)
				quiet = 1'b1;
			fed = 0;
			while (fed < PHASE_ITEMS) begin
				lead = ($urandom_range(0, 9) == 0) ? "-" : pick_letter();
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
				feed_column(lead, len, fed);
			end
		end

		wait_idle();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
